[sv/sha_pkg.sv]
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       start;
    logic       wr;
    logic [3:0] addr;
    word_t      w_in;
  } round_ctl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

[sv/sha256_stream_hasher.sv]
// Top level of the SHA-256 stream hasher.
`timescale 1ns / 1ps
`default_nettype none
// Message words enter on the in channel (valid_i/stall_o), one at a time: stall_o is high
// from the cycle after a transfer until the word is fully handled. A word is accepted, its
// valid bytes are written into the block in turn, and a closing step follows.
// A word that fills a 64-byte block also waits for the shared round unit. A last word
// then pads one byte per cycle (up to 72 bytes) while no block is being compressed, runs
// one or two compressions, and delivers the eight digest words, one transfer each.
module sha256_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_item_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StBytes = 5'b00010,
    StPad   = 5'b00100,
    StComp  = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e          state_q, state_d, ret_q;
  sha_pkg::word_t  chain_q [8];
  sha_pkg::word_t  sum [8];
  logic [63:0]     cnt_q;
  logic [31:0]     word_q;
  logic [2:0]      nb_q, bi_q;
  logic            last_q, pad80_q, len_ok_q;
  logic [5:0]      pos_q;
  logic [23:0]     acc_q;
  logic [2:0]      oi_q;
  logic            done;
  sha_pkg::round_ctl_t ctl;
  logic [7:0]      byte_v;
  logic [63:0]     bits;
  logic            wr_en;
  logic [7:0]      wr_b;
  logic            final_blk;

  sha_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .chain_i(chain_q),
    .done_o (done),
    .sum_o  (sum)
  );

  assign bits = {cnt_q[60:0], 3'b000};

  // Byte to write this cycle during padding: 0x80, zeros, then length bytes.
  always_comb begin
    if (!pad80_q) byte_v = sha_pkg::PadByte;
    else if (len_ok_q && pos_q >= 6'd56) byte_v = 8'(bits >> {~pos_q[2:0], 3'b000});
    else byte_v = 8'h00;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_b  = byte_v;
    if (state_q == StBytes && bi_q < nb_q) begin
      wr_en = 1'b1;
      wr_b  = 8'(word_q >> {~bi_q[1:0], 3'b000});
    end else if (state_q == StPad) begin
      wr_en = 1'b1;
    end
  end

  assign final_blk = state_q == StPad && pad80_q && len_ok_q;
  assign ctl.start = wr_en && pos_q == 6'd63;
  assign ctl.wr    = wr_en && pos_q[1:0] == 2'd3;
  assign ctl.addr  = pos_q[5:2];
  assign ctl.w_in  = {acc_q, wr_b};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (valid_i) state_d = StBytes;
      StBytes: begin
        if (ctl.start) state_d = StComp;
        else if (!(bi_q < nb_q)) state_d = last_q ? StPad : StIdle;
      end
      StPad:   if (ctl.start) state_d = StComp;
      StComp:  if (done) state_d = ret_q;
      StOut:   if (!stall_i && oi_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ret_q    <= StIdle;
      cnt_q    <= '0;
      word_q   <= '0;
      acc_q    <= '0;
      pos_q    <= '0;
      bi_q     <= '0;
      nb_q     <= '0;
      last_q   <= 1'b0;
      pad80_q  <= 1'b0;
      len_ok_q <= 1'b0;
      oi_q     <= '0;
      for (int j = 0; j < 8; j++) chain_q[j] <= sha_pkg::InitH[j];
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && valid_i) begin
        word_q <= data_word_i;
        nb_q   <= (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
        last_q <= last_item_i;
        bi_q   <= '0;
      end
      if (ctl.start) ret_q <= final_blk ? StOut : state_q;
      if (wr_en) begin
        acc_q <= {acc_q[15:0], wr_b};
        pos_q <= pos_q + 6'd1;
        if (state_q == StBytes) begin
          bi_q  <= bi_q + 3'd1;
          cnt_q <= cnt_q + 64'd1;
        end else begin
          pad80_q <= 1'b1;
          // The length goes in the next block unless 0x80 landed before byte 56.
          if (pos_q == 6'd63) len_ok_q <= 1'b1;
          else if (!pad80_q) len_ok_q <= pos_q < 6'd56;
        end
      end
      if (done) begin
        for (int j = 0; j < 8; j++) chain_q[j] <= sum[j];
      end
      if (state_q == StOut && !stall_i) begin
        oi_q <= oi_q + 3'd1;
        if (oi_q == 3'd7) begin
          for (int j = 0; j < 8; j++) chain_q[j] <= sha_pkg::InitH[j];
          cnt_q    <= '0;
          pad80_q  <= 1'b0;
          len_ok_q <= 1'b0;
        end
      end
    end
  end

  assign stall_o       = state_q != StIdle;
  assign valid_o       = state_q == StOut;
  assign digest_word_o = chain_q[oi_q];
  assign word_index_o  = oi_q;
  assign last_word_o   = oi_q == 3'd7;

endmodule
`default_nettype wire

[sv/sha_core.sv]
// Iterative SHA-256 compression unit, one round per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sha_pkg::round_ctl_t  ctl_i,
  input  wire sha_pkg::word_t       chain_i [8],
  output logic                      done_o,
  output sha_pkg::word_t            sum_o [8]
);

  sha_pkg::word_t wv_q [8];
  sha_pkg::word_t win_q [16];
  logic [5:0]     rnd_q;
  logic           busy_q, done_q;

  sha_pkg::word_t w, t1, t2, ch, mj, s0e, s0a;

  always_comb begin
    if (rnd_q < 6'd16) begin
      w = win_q[rnd_q[3:0]];
    end else begin
      w = sha_pkg::sig1(win_q[rnd_q[3:0] - 4'd2]) + win_q[rnd_q[3:0] - 4'd7]
          + sha_pkg::sig0(win_q[rnd_q[3:0] - 4'd15]) + win_q[rnd_q[3:0]];
    end
    ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
    mj  = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
    s0e = sha_pkg::rotr(wv_q[4], 6) ^ sha_pkg::rotr(wv_q[4], 11)
          ^ sha_pkg::rotr(wv_q[4], 25);
    s0a = sha_pkg::rotr(wv_q[0], 2) ^ sha_pkg::rotr(wv_q[0], 13)
          ^ sha_pkg::rotr(wv_q[0], 22);
    t1  = wv_q[7] + s0e + ch + sha_pkg::RoundK[rnd_q] + w;
    t2  = s0a + mj;
  end

  // Message words are written up to and including the start cycle; a start loads the working variables.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        rnd_q <= rnd_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int j = 0; j < 8; j++) wv_q[j] <= chain_i[j];
    end else if (busy_q) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
    if (ctl_i.wr) begin
      win_q[ctl_i.addr] <= ctl_i.w_in;
    end else if (busy_q) begin
      win_q[rnd_q[3:0]] <= w;
    end
  end

  assign done_o = done_q;
  always_comb begin
    for (int j = 0; j < 8; j++) sum_o[j] = chain_i[j] + wv_q[j];
  end

endmodule
`default_nettype wire
